@@ hw/rtl/mva_pkg.sv @@
package mva_pkg;

  // Voice pool size and the index width that follows from it
  localparam int VOICES  = 3;
  localparam int VI_W    = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Port widths fixed by the message format
  localparam int STATUS_W = 8;
  localparam int DATA_W   = 7;
  localparam int OUT_VI_W = 3;

  // Status byte decoding
  localparam logic [STATUS_W-1:0] ST_REALTIME = 8'hF8;
  localparam logic [3:0]          NIB_OFF     = 4'h8;
  localparam logic [3:0]          NIB_ON      = 4'h9;
  localparam logic [3:0]          NIB_CTRL    = 4'hB;
  localparam logic [DATA_W-1:0]   CC_SOUND_OFF = 7'd120;
  localparam logic [DATA_W-1:0]   CC_NOTES_OFF = 7'd123;

  // What a captured message asks for
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_ON   = 2'd2,
    KIND_ALL  = 2'd3
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic step;     // apply one start or release and load the output register
  } mva_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result; // the pending message still has a result to give
    logic last;       // that result is the final one
    logic out_free;   // output register can take a word this cycle
  } mva_sts_t;

endpackage

@@ hw/rtl/mva_ctrl.sv @@
module mva_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output mva_pkg::mva_cmd_t cmd,
  input  mva_pkg::mva_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Take a word only when idle
  assign in_stall = (state_r != S_IDLE);

  // Sequence: capture, then one step per result until the last one, or back to idle when there is none
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.has_result) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/mva_dp.sv @@
module mva_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mva_pkg::mva_cmd_t                cmd,
  output mva_pkg::mva_sts_t                sts,
  input  logic [mva_pkg::STATUS_W-1:0]     in_status_byte,
  input  logic [mva_pkg::DATA_W-1:0]       in_first_data,
  input  logic [mva_pkg::DATA_W-1:0]       in_second_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mva_pkg::OUT_VI_W-1:0]     out_voice_index,
  output logic [mva_pkg::DATA_W-1:0]       out_note_number,
  output logic [mva_pkg::DATA_W-1:0]       out_velocity,
  output logic                             out_last_result
);

  // Captured message
  mva_pkg::kind_t               kind_r;
  logic [mva_pkg::DATA_W-1:0]   note_r;
  logic [mva_pkg::DATA_W-1:0]   vel_r;

  // Voice state
  logic [mva_pkg::VOICES-1:0]   act_r;
  logic [mva_pkg::DATA_W-1:0]   vnote_r [mva_pkg::VOICES];
  logic [mva_pkg::VI_W-1:0]     rank_r  [mva_pkg::VOICES];

  // Output register
  logic                         out_valid_r;
  logic [mva_pkg::VI_W-1:0]     out_idx_r;
  logic [mva_pkg::DATA_W-1:0]   out_note_r;
  logic [mva_pkg::DATA_W-1:0]   out_vel_r;
  logic                         out_last_r;

  mva_pkg::kind_t               kind_nxt;

  logic                         free_hit, match_hit, act_hit;
  logic [mva_pkg::VI_W-1:0]     free_idx, old_idx, match_idx, act_idx;
  logic [mva_pkg::VOICES-1:0]   rest_mask;
  logic                         sel_hit, sel_last;
  logic [mva_pkg::VI_W-1:0]     sel_idx;
  logic [mva_pkg::VI_W-1:0]     sel_rank;
  logic [mva_pkg::DATA_W-1:0]   res_note, res_vel;

  // Decode the incoming word; the channel nibble plays no part
  always_comb begin
    kind_nxt = mva_pkg::KIND_NONE;
    if (in_status_byte < mva_pkg::ST_REALTIME) begin
      case (in_status_byte[7:4])
        mva_pkg::NIB_OFF: kind_nxt = mva_pkg::KIND_OFF;
        mva_pkg::NIB_ON: begin
          kind_nxt = (in_second_data == '0) ? mva_pkg::KIND_OFF : mva_pkg::KIND_ON;
        end
        mva_pkg::NIB_CTRL: begin
          if (in_first_data inside {mva_pkg::CC_SOUND_OFF, mva_pkg::CC_NOTES_OFF}) begin
            kind_nxt = mva_pkg::KIND_ALL;
          end
        end
        default: kind_nxt = mva_pkg::KIND_NONE;
      endcase
    end
  end

  // Priority searches over the voices, lowest index wins
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    old_idx   = '0;
    match_hit = 1'b0;
    match_idx = '0;
    act_hit   = 1'b0;
    act_idx   = '0;
    for (int i = mva_pkg::VOICES - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_hit = 1'b1;
        free_idx = mva_pkg::VI_W'(i);
      end
      if (rank_r[i] == '0) begin
        old_idx = mva_pkg::VI_W'(i);
      end
      if (act_r[i] && vnote_r[i] == note_r) begin
        match_hit = 1'b1;
        match_idx = mva_pkg::VI_W'(i);
      end
      if (act_r[i]) begin
        act_hit = 1'b1;
        act_idx = mva_pkg::VI_W'(i);
      end
    end
    rest_mask          = act_r;
    rest_mask[act_idx] = 1'b0;
  end

  // Pick the voice for this step and what it reports
  always_comb begin
    sel_hit  = 1'b0;
    sel_last = 1'b1;
    sel_idx  = '0;
    res_note = note_r;
    res_vel  = '0;
    case (kind_r)
      mva_pkg::KIND_OFF: begin
        sel_hit = match_hit;
        sel_idx = match_idx;
      end
      mva_pkg::KIND_ON: begin
        sel_hit = 1'b1;
        sel_idx = free_hit ? free_idx : old_idx;
        res_vel = vel_r;
      end
      mva_pkg::KIND_ALL: begin
        sel_hit  = act_hit;
        sel_idx  = act_idx;
        sel_last = (rest_mask == '0);
        res_note = vnote_r[act_idx];
      end
      default: sel_hit = 1'b0;
    endcase
    sel_rank = rank_r[sel_idx];
  end

  assign sts.has_result = sel_hit;
  assign sts.last       = sel_last;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Hold the captured message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= mva_pkg::KIND_NONE;
    end else if (cmd.capture) begin
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      note_r <= in_first_data;
      vel_r  <= in_second_data;
    end
  end

  // Update activity on each step, and recency on each start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      for (int i = 0; i < mva_pkg::VOICES; i++) begin
        rank_r[i] <= mva_pkg::VI_W'(i);
      end
    end else if (cmd.step) begin
      act_r[sel_idx] <= (kind_r == mva_pkg::KIND_ON);
      if (kind_r == mva_pkg::KIND_ON) begin
        for (int i = 0; i < mva_pkg::VOICES; i++) begin
          if (mva_pkg::VI_W'(i) == sel_idx) begin
            rank_r[i] <= mva_pkg::VI_W'(mva_pkg::VOICES - 1);
          end else if (rank_r[i] > sel_rank) begin
            rank_r[i] <= rank_r[i] - 1'b1;
          end
        end
      end
    end
  end

  // Note store, written on a start
  always_ff @(posedge clk) begin
    if (cmd.step && kind_r == mva_pkg::KIND_ON) begin
      vnote_r[sel_idx] <= note_r;
    end
  end

  // Output register: load on a step, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_idx_r  <= sel_idx;
      out_note_r <= res_note;
      out_vel_r  <= res_vel;
      out_last_r <= sel_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_voice_index = mva_pkg::OUT_VI_W'(out_idx_r);
  assign out_note_number = out_note_r;
  assign out_velocity    = out_vel_r;
  assign out_last_result = out_last_r;

endmodule

@@ hw/rtl/midi_voice_allocator.sv @@
// MIDI voice allocator: maps note messages onto a small pool of voices.
// Input channel (in_*): one assembled MIDI message per word, taken when
// in_valid is high and in_stall low. in_stall is high from the cycle after a
// word is taken until every result of that word has been loaded for output.
// Result channel (out_*): one word per voice start or release, held in an
// output register until out_stall is low; out_last_result marks the final
// result of a message. Messages that cause nothing give no word at all.
// A message is first captured; each result is then loaded into the output
// register by a step of the execute state, which waits while the output
// register is full and stalled. An all-notes-off gives one result per
// active voice, and input stays stalled until the last one is loaded. The
// output register lets the next message be taken while a result still waits.
// A stalled receiver holds the output word; a further result then waits in
// the execute state, and input stays stalled until it is loaded.
// Reset (rst_n low at a clock edge) releases all voices, restores the
// recency order to voice index order and empties the output register.
module midi_voice_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mva_pkg::STATUS_W-1:0]     in_status_byte,
  input  logic [mva_pkg::DATA_W-1:0]       in_first_data,
  input  logic [mva_pkg::DATA_W-1:0]       in_second_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mva_pkg::OUT_VI_W-1:0]     out_voice_index,
  output logic [mva_pkg::DATA_W-1:0]       out_note_number,
  output logic [mva_pkg::DATA_W-1:0]       out_velocity,
  output logic                             out_last_result
);

  mva_pkg::mva_cmd_t cmd;
  mva_pkg::mva_sts_t sts;

  mva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  mva_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_status_byte  (in_status_byte),
    .in_first_data   (in_first_data),
    .in_second_data  (in_second_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_voice_index (out_voice_index),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_last_result (out_last_result)
  );

endmodule

@@ hw/rtl/mva_checker.sv @@
module mva_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [mva_pkg::OUT_VI_W-1:0] out_voice_index,
  input logic [mva_pkg::DATA_W-1:0]   out_note_number,
  input logic [mva_pkg::DATA_W-1:0]   out_velocity,
  input logic                         out_last_result
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  // A taken word is followed by a stall on the input
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on two consecutive cycles");

  // While a non-final result word is shown, no new word is taken
  a_hold_mid_message: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |-> in_stall)
    else $error("input taken before the final result of a message");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_voice_index) &&
      $stable(out_note_number) && $stable(out_velocity) && $stable(out_last_result)))
    else $error("stalled result word changed");

endmodule

bind midi_voice_allocator mva_checker u_mva_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_voice_index (out_voice_index),
  .out_note_number (out_note_number),
  .out_velocity    (out_velocity),
  .out_last_result (out_last_result)
);

@@ sim/mva_checker.sv @@
`timescale 1ns / 100ps

module mva_scoreboard (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [mva_pkg::STATUS_W-1:0] in_status_byte,
  input  logic [mva_pkg::DATA_W-1:0]   in_first_data,
  input  logic [mva_pkg::DATA_W-1:0]   in_second_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [mva_pkg::OUT_VI_W-1:0] out_voice_index,
  input  logic [mva_pkg::DATA_W-1:0]   out_note_number,
  input  logic [mva_pkg::DATA_W-1:0]   out_velocity,
  input  logic                         out_last_result,
  output int                           pending_words,
  output int                           checked_words,
  output int                           fail_count
);

  typedef struct packed {
    logic [mva_pkg::OUT_VI_W-1:0] voice;
    logic [mva_pkg::DATA_W-1:0]   note;
    logic [mva_pkg::DATA_W-1:0]   vel;
    logic                         last;
  } voice_event_t;

  // Voice events still owed by the block, oldest first
  voice_event_t voice_events_q[$];

  // Own copy of the voice pool
  logic                       busy      [mva_pkg::VOICES];
  logic [mva_pkg::DATA_W-1:0] held_note [mva_pkg::VOICES];
  int                         age_rank  [mva_pkg::VOICES];

  int faults;
  int seen;

  // Queue one expected word behind the others
  function automatic void owe_event(input voice_event_t ev);
    voice_events_q = {voice_events_q, ev};
  endfunction

  always @(posedge clk) begin : track
    voice_event_t   got;
    voice_event_t   want;
    mva_pkg::kind_t kind;
    logic [3:0]     nib;
    int             pick;
    int             owed;
    int             k;
    int             old_rank;

    if (!rst_n) begin
      // Clear the pool and restore index order of age
      voice_events_q.delete();
      faults = 0;
      seen   = 0;
      for (int i = 0; i < mva_pkg::VOICES; i++) begin
        busy[i]      = 1'b0;
        held_note[i] = '0;
        age_rank[i]  = i;
      end
    end else begin
      // Compare an accepted result word with the oldest expected event
      if (out_valid && !out_stall) begin
        got.voice = out_voice_index;
        got.note  = out_note_number;
        got.vel   = out_velocity;
        got.last  = out_last_result;
        seen++;
        if (voice_events_q.size() == 0) begin
          if (faults < 10)
            $display("%0t: unexpected word voice %0d note %0d vel %0d last %0b",
                     $realtime, got.voice, got.note, got.vel, got.last);
          faults++;
        end else begin
          want = voice_events_q.pop_front();
          if (got.voice !== want.voice || got.note !== want.note ||
              got.vel !== want.vel || got.last !== want.last) begin
            if (faults < 10)
              $display({"%0t: mismatch: expected voice %0d note %0d vel %0d last %0b,",
                        " got voice %0d note %0d vel %0d last %0b"},
                       $realtime, want.voice, want.note, want.vel, want.last,
                       got.voice, got.note, got.vel, got.last);
            faults++;
          end
        end
      end

      // Decode an accepted message word
      if (in_valid && !in_stall) begin
        nib  = in_status_byte[7:4];
        kind = mva_pkg::KIND_NONE;
        if (in_status_byte < mva_pkg::ST_REALTIME) begin
          if (nib == mva_pkg::NIB_OFF)
            kind = mva_pkg::KIND_OFF;
          else if (nib == mva_pkg::NIB_ON)
            kind = (in_second_data == '0) ? mva_pkg::KIND_OFF : mva_pkg::KIND_ON;
          else if (nib == mva_pkg::NIB_CTRL &&
                   (in_first_data inside {mva_pkg::CC_SOUND_OFF, mva_pkg::CC_NOTES_OFF}))
            kind = mva_pkg::KIND_ALL;
        end

        case (kind)
          mva_pkg::KIND_OFF: begin
            // Release the lowest active voice holding this note, if any
            pick = -1;
            for (int i = 0; i < mva_pkg::VOICES; i++)
              if (pick < 0 && busy[i] && held_note[i] == in_first_data)
                pick = i;
            if (pick >= 0) begin
              busy[pick] = 1'b0;
              want.voice = mva_pkg::OUT_VI_W'(pick);
              want.note  = in_first_data;
              want.vel   = '0;
              want.last  = 1'b1;
              owe_event(want);
            end
          end
          mva_pkg::KIND_ON: begin
            // Take the lowest free voice, else steal the oldest assignment
            pick = -1;
            for (int i = 0; i < mva_pkg::VOICES; i++)
              if (pick < 0 && !busy[i])
                pick = i;
            if (pick < 0) begin
              pick = 0;
              for (int i = mva_pkg::VOICES - 1; i >= 0; i--)
                if (age_rank[i] == 0)
                  pick = i;
            end
            busy[pick]      = 1'b1;
            held_note[pick] = in_first_data;
            // Make the chosen voice the newest
            old_rank = age_rank[pick];
            for (int i = 0; i < mva_pkg::VOICES; i++)
              if (age_rank[i] > old_rank)
                age_rank[i]--;
            age_rank[pick] = mva_pkg::VOICES - 1;
            want.voice = mva_pkg::OUT_VI_W'(pick);
            want.note  = in_first_data;
            want.vel   = in_second_data;
            want.last  = 1'b1;
            owe_event(want);
          end
          mva_pkg::KIND_ALL: begin
            // Release every active voice in index order
            owed = 0;
            for (int i = 0; i < mva_pkg::VOICES; i++)
              if (busy[i])
                owed++;
            k = 0;
            for (int i = 0; i < mva_pkg::VOICES; i++) begin
              if (busy[i]) begin
                want.voice = mva_pkg::OUT_VI_W'(i);
                want.note  = held_note[i];
                want.vel   = '0;
                want.last  = (k == owed - 1);
                owe_event(want);
                k++;
              end
              busy[i] = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end

    pending_words <= voice_events_q.size();
    checked_words <= seen;
    fail_count    <= faults;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TOTAL  = 450;

  // Message kinds the block ignores
  localparam logic [3:0]                 NIB_POLY_AT = 4'hA;
  localparam logic [3:0]                 NIB_PROGRAM = 4'hC;
  localparam logic [3:0]                 NIB_BEND    = 4'hE;
  localparam logic [3:0]                 NIB_SYSTEM  = 4'hF;
  localparam logic [mva_pkg::DATA_W-1:0] CC_VOLUME   = 7'd7;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [mva_pkg::STATUS_W-1:0] in_status_byte;
  logic [mva_pkg::DATA_W-1:0]   in_first_data;
  logic [mva_pkg::DATA_W-1:0]   in_second_data;
  logic                         out_valid;
  logic                         out_stall;
  logic [mva_pkg::OUT_VI_W-1:0] out_voice_index;
  logic [mva_pkg::DATA_W-1:0]   out_note_number;
  logic [mva_pkg::DATA_W-1:0]   out_velocity;
  logic                         out_last_result;

  int   pending_words;
  int   checked_words;
  int   fail_count;
  int   words_sent;
  int   note_items;
  int   cycle_count;
  logic tx_idle;
  logic rx_idle;

  midi_voice_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_status_byte  (in_status_byte),
    .in_first_data   (in_first_data),
    .in_second_data  (in_second_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_voice_index (out_voice_index),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_last_result (out_last_result)
  );

  mva_scoreboard chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_status_byte  (in_status_byte),
    .in_first_data   (in_first_data),
    .in_second_data  (in_second_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_voice_index (out_voice_index),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_last_result (out_last_result),
    .pending_words   (pending_words),
    .checked_words   (checked_words),
    .fail_count      (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run if the block hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d voice words still owed",
             cycle_count, pending_words);
    $display("** midi_voice_allocator: FAILED **");
    $finish;
  end

  // Receiver: while rx_idle is set, stall for a random time before taking each word
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      hold = rx_idle ? $urandom_range(0, 5) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one message word, after a random gap while tx_idle is set, and hold it until taken
  task automatic send_word(input logic [mva_pkg::STATUS_W-1:0] st,
                           input logic [mva_pkg::DATA_W-1:0] d1,
                           input logic [mva_pkg::DATA_W-1:0] d2);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_status_byte <= st;
    in_first_data  <= d1;
    in_second_data <= d2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop the offer and hold off until every expected voice word has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  function automatic logic [mva_pkg::DATA_W-1:0] pick_note();
    if ($urandom_range(0, 4) != 0)
      return mva_pkg::DATA_W'($urandom_range(58, 63));
    return mva_pkg::DATA_W'($urandom_range(0, 127));
  endfunction

  initial begin : stimulus
    int                         roll;
    int                         next_mode_at;
    int                         next_drain_at;
    logic [1:0]                 mode;
    logic [3:0]                 chan;
    logic [mva_pkg::DATA_W-1:0] ctrl;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_status_byte = '0;
    in_first_data  = '0;
    in_second_data = '0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    words_sent     = 0;
    note_items     = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the pool, then steal the two oldest voices
    send_word({mva_pkg::NIB_ON, 4'h0}, 7'd0, 7'd127);
    send_word({mva_pkg::NIB_ON, 4'hF}, 7'd127, 7'd1);
    send_word({mva_pkg::NIB_ON, 4'h3}, 7'd64, 7'd64);
    send_word({mva_pkg::NIB_ON, 4'h0}, 7'd10, 7'd100);
    send_word({mva_pkg::NIB_ON, 4'h0}, 7'd20, 7'd90);
    // Unmatched release, velocity-zero release, note-off on the top channel
    send_word({mva_pkg::NIB_OFF, 4'h0}, 7'd99, 7'd0);
    send_word({mva_pkg::NIB_ON, 4'h1}, 7'd64, 7'd0);
    send_word({mva_pkg::NIB_OFF, 4'hF}, 7'd20, 7'd127);
    // Realtime, system, other kinds, ordinary controller, data byte as status
    send_word(mva_pkg::ST_REALTIME, 7'd10, 7'd0);
    send_word(8'hFF, 7'd10, 7'd127);
    send_word({NIB_SYSTEM, 4'h0}, 7'd10, 7'd0);
    send_word({NIB_SYSTEM, 4'h7}, 7'd10, 7'd0);
    send_word({NIB_PROGRAM, 4'h3}, 7'd10, 7'd0);
    send_word({NIB_BEND, 4'h5}, 7'd127, 7'd127);
    send_word({NIB_POLY_AT, 4'h0}, 7'd10, 7'd64);
    send_word({mva_pkg::NIB_CTRL, 4'h0}, CC_VOLUME, 7'd100);
    send_word(8'h00, 7'd10, 7'd0);
    // All notes off with one voice busy, then again with none
    send_word({mva_pkg::NIB_CTRL, 4'h2}, mva_pkg::CC_NOTES_OFF, 7'd0);
    send_word({mva_pkg::NIB_CTRL, 4'h2}, mva_pkg::CC_SOUND_OFF, 7'd0);
    // Duplicate notes: release takes the lowest index
    send_word({mva_pkg::NIB_ON, 4'h0}, 7'd50, 7'd5);
    send_word({mva_pkg::NIB_ON, 4'h0}, 7'd50, 7'd6);
    send_word({mva_pkg::NIB_ON, 4'h0}, 7'd51, 7'd7);
    send_word({mva_pkg::NIB_OFF, 4'h0}, 7'd50, 7'd0);
    send_word({mva_pkg::NIB_CTRL, 4'h9}, mva_pkg::CC_SOUND_OFF, 7'd127);
    send_word({mva_pkg::NIB_OFF, 4'h0}, 7'd50, 7'd0);

    wait_drained();

    // Random traffic: mostly note traffic, some noise
    next_mode_at  = 0;
    next_drain_at = 150;
    while (words_sent < ITEM_TOTAL) begin
      if (note_items >= next_mode_at) begin
        mode          = 2'($urandom_range(0, 3));
        tx_idle       = mode[0];
        rx_idle      <= mode[1];
        next_mode_at += 40;
      end
      if (note_items >= next_drain_at) begin
        wait_drained();
        next_drain_at += 150;
      end
      chan = 4'($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        send_word({mva_pkg::NIB_ON, chan}, pick_note(),
                  mva_pkg::DATA_W'($urandom_range(1, 127)));
        note_items++;
      end else if (roll < 60) begin
        send_word({mva_pkg::NIB_OFF, chan}, pick_note(),
                  mva_pkg::DATA_W'($urandom_range(0, 127)));
        note_items++;
      end else if (roll < 70) begin
        send_word({mva_pkg::NIB_ON, chan}, pick_note(), '0);
        note_items++;
      end else if (roll < 78) begin
        ctrl = $urandom_range(0, 1) ? mva_pkg::CC_SOUND_OFF : mva_pkg::CC_NOTES_OFF;
        send_word({mva_pkg::NIB_CTRL, chan}, ctrl,
                  mva_pkg::DATA_W'($urandom_range(0, 127)));
        note_items++;
      end else if (roll < 85) begin
        send_word({mva_pkg::NIB_CTRL, chan}, mva_pkg::DATA_W'($urandom_range(0, 127)),
                  mva_pkg::DATA_W'($urandom_range(0, 127)));
      end else begin
        send_word(mva_pkg::STATUS_W'($urandom_range(0, 255)),
                  mva_pkg::DATA_W'($urandom_range(0, 127)),
                  mva_pkg::DATA_W'($urandom_range(0, 127)));
      end
    end

    // Let the last results come out, then idle before the report
    wait_drained();
    repeat (20) @(posedge clk);

    $display("messages sent: %0d (%0d random note and release items)",
             words_sent, note_items);
    $display("voice words checked: %0d, mismatches: %0d", checked_words, fail_count);
    if (fail_count == 0) begin
      $display("** midi_voice_allocator: PASSED **");
    end else begin
      $display("** midi_voice_allocator: FAILED **");
    end
    $finish;
  end

endmodule
